[sv/dls_pkg.sv]
// ---------------------------------------------------------------------------
// dls_pkg
// Shared types, codes and ring-index helpers for the double-ended list store.
// ---------------------------------------------------------------------------
package dls_pkg;

  // capacity of the ring, 2..64
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);
  localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_DROP_FRONT = 3'd2;
  localparam logic [2:0] REQ_DROP_BACK  = 3'd3;
  localparam logic [2:0] REQ_DUMP       = 3'd4;
  localparam logic [2:0] REQ_CLEAR      = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } dls_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     final_item;
  } dls_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } dls_state_e;

  function automatic idx_t ring_inc(idx_t idx);
    return (idx == IDX_LAST) ? '0 : idx_t'(idx + 1'b1);
  endfunction

  function automatic idx_t ring_dec(idx_t idx);
    return (idx == '0) ? IDX_LAST : idx_t'(idx - 1'b1);
  endfunction

  // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

[sv/double_ended_list_store_top.sv]
// ---------------------------------------------------------------------------
// double_ended_list_store_top
// Double-ended queue of signed 32-bit words kept in a ring inside one RAM.
// ---------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  --------+-----+----------------------+-----------------------------------
//  in      | in  | in_valid_i/in_stall_o  | req_type, push_value
//  out     | out | out_valid_o/out_stall_i | status, element, final_item
//
//  push, drop, clear and error requests are each handled in the cycle they are accepted.
//  a dump starts, then makes one RAM read per element through the single
//  memory port while the output buffer has room; read data is registered;
//  intake stalls meanwhile.
//  a two-word output buffer lets new requests in while results wait.
//  reset empties the list at once; RAM contents stay undefined until pushed.
// ---------------------------------------------------------------------------
module double_ended_list_store_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dls_pkg::dls_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dls_pkg::dls_out_t out_o
);
  import dls_pkg::*;

  dls_state_e state_q, state_d;
  idx_t       front_q, front_d;
  cnt_t       count_q, count_d;
  cnt_t       pos_q;
  idx_t       rd_slot_q;
  logic       pend_q, pend_last_q;

  dls_out_t   fifo_q [2];
  logic       fifo_wr_q, fifo_rd_q;
  logic [1:0] fifo_cnt_q;

  logic       in_acc, out_pop, fifo_we;
  logic       list_full, list_empty;
  logic       dump_start, issue, dump_last;
  logic       err_valid;
  logic [1:0] err_status;
  logic [2:0] occ;
  dls_out_t   fifo_wdata;

  logic              mem_en, mem_we;
  idx_t              mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  assign in_stall_o = (state_q != ST_IDLE) || pend_q || (fifo_cnt_q == 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (fifo_cnt_q != 2'd0);
  assign out_pop    = out_valid_o && !out_stall_i;
  assign out_o      = fifo_q[fifo_rd_q];

  assign list_full  = (count_q == CNT_FULL);
  assign list_empty = (count_q == '0);

  // occupancy the buffer will have, counting the read in flight
  assign occ       = 3'({1'b0, fifo_cnt_q}) + 3'(pend_q) - 3'(out_pop);
  assign issue     = (state_q == ST_DUMP) && (occ < 3'd2);
  assign dump_last = (cnt_t'(pos_q + 1'b1) == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (dump_start) state_d = ST_DUMP;
      ST_DUMP: if (issue && dump_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // request decode and memory control
  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    dump_start = 1'b0;
    err_valid  = 1'b0;
    err_status = STATUS_OK;
    mem_en     = issue;
    mem_we     = 1'b0;
    mem_addr   = rd_slot_q;
    mem_wdata  = in_i.push_value;
    if (in_acc) begin
      unique case (in_i.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (list_full) begin
            err_valid  = 1'b1;
            err_status = STATUS_FULL;
          end else begin
            mem_en  = 1'b1;
            mem_we  = 1'b1;
            count_d = cnt_t'(count_q + 1'b1);
            if (in_i.req_type == REQ_PUSH_FRONT) begin
              front_d  = ring_dec(front_q);
              mem_addr = ring_dec(front_q);
            end else begin
              mem_addr = ring_add(front_q, count_q);
            end
          end
        end
        REQ_DROP_FRONT, REQ_DROP_BACK: begin
          if (list_empty) begin
            err_valid  = 1'b1;
            err_status = STATUS_EMPTY;
          end else begin
            count_d = cnt_t'(count_q - 1'b1);
            if (in_i.req_type == REQ_DROP_FRONT) begin
              front_d = ring_inc(front_q);
            end
          end
        end
        REQ_DUMP: dump_start = !list_empty;
        REQ_CLEAR: begin
          front_d = '0;
          count_d = '0;
        end
        default: ;
      endcase
    end
  end

  // read data and errors never land in the same cycle: intake waits on pend_q
  assign fifo_we = pend_q || err_valid;
  always_comb begin
    if (pend_q) begin
      fifo_wdata = '{status: STATUS_OK, element: mem_rdata, final_item: pend_last_q};
    end else begin
      fifo_wdata = '{status: err_status, element: '0, final_item: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      rd_slot_q   <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      fifo_wr_q   <= 1'b0;
      fifo_rd_q   <= 1'b0;
      fifo_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      pend_q  <= issue;
      if (dump_start) begin
        pos_q     <= '0;
        rd_slot_q <= front_q;
      end else if (issue) begin
        pos_q       <= cnt_t'(pos_q + 1'b1);
        rd_slot_q   <= ring_inc(rd_slot_q);
        pend_last_q <= dump_last;
      end
      if (fifo_we) fifo_wr_q <= !fifo_wr_q;
      if (out_pop) fifo_rd_q <= !fifo_rd_q;
      fifo_cnt_q <= fifo_cnt_q + 2'(fifo_we) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[fifo_wr_q] <= fifo_wdata;
    end
  end

  dls_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (mem_en),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

[sv/dls_ram.sv]
// ---------------------------------------------------------------------------
// dls_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module dls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dls_chk.sv]
// ---------------------------------------------------------------------------
// dls_chk
// Port-level checks for the double-ended list store, bound to the top level.
// ---------------------------------------------------------------------------
module dls_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input dls_pkg::dls_in_t  in_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dls_pkg::dls_out_t out_o
);
  import dls_pkg::*;

  // a stalled request word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_i))
    else $error("request word changed under stall");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("result word changed under stall");

  // error words carry zero and close their request
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != STATUS_OK) |->
      (out_o.element == '0) && out_o.final_item)
    else $error("malformed error word");

  // while a dump still has words to come, no request is taken
  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == STATUS_OK) && !out_o.final_item |-> in_stall_o)
    else $error("request taken in the middle of a dump");

  // only defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.status == STATUS_OK) || (out_o.status == STATUS_EMPTY) ||
                    (out_o.status == STATUS_FULL))
    else $error("undefined status code");

endmodule

bind double_ended_list_store_top dls_chk u_dls_chk (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for double_ended_list_store_top. It drives pushes, drops, dumps
// and clears, with random gaps on the request side and random stalls on the
// result side. A shadow copy of the ring computes the result words that each
// accepted request should give. Every result word is checked in order.
// ---------------------------------------------------------------------------
module tb_top;
  import dls_pkg::*;

  localparam int RING_SLOTS   = int'(DEPTH);
  // slowest correct run: ~530 requests, each a full dump of 64 words with
  // every word held by the longest result stall; the limit allows 4x that
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int SETTLE_TICKS = RING_SLOTS + 16;

  // request codes the block ignores
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  dls_in_t  in_i;
  logic     out_valid_o;
  logic     out_stall_i;
  dls_out_t out_o;

  double_ended_list_store_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // shadow of the list held by the block
  logic signed [DATA_W-1:0] shadow_ring [RING_SLOTS];
  idx_t                     shadow_head = '0;
  cnt_t                     shadow_len  = '0;

  dls_out_t pending_results [$];
  dls_out_t seen_word;
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  bit       calm           = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL double_ended_list_store_top");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  function automatic logic signed [DATA_W-1:0] any_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int ring_pos(input int offset);
    return (int'(shadow_head) + offset) % RING_SLOTS;
  endfunction

  // expected result words for one accepted request, and the state update
  task automatic model_request(input dls_in_t w);
    dls_out_t r;
    int       pos;
    r = '0;
    r.final_item = 1'b1;
    case (w.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (int'(shadow_len) >= RING_SLOTS) begin
          r.status = STATUS_FULL;
          pending_results.push_back(r);
        end else if (w.req_type == REQ_PUSH_FRONT) begin
          shadow_head = idx_t'(ring_pos(RING_SLOTS - 1));
          shadow_ring[shadow_head] = w.push_value;
          shadow_len++;
        end else begin
          shadow_ring[ring_pos(int'(shadow_len))] = w.push_value;
          shadow_len++;
        end
      end
      REQ_DROP_FRONT, REQ_DROP_BACK: begin
        if (shadow_len == '0) begin
          r.status = STATUS_EMPTY;
          pending_results.push_back(r);
        end else begin
          if (w.req_type == REQ_DROP_FRONT) begin
            shadow_head = idx_t'(ring_pos(1));
          end
          shadow_len--;
        end
      end
      REQ_DUMP: begin
        for (pos = 0; pos < int'(shadow_len); pos++) begin
          r.status     = STATUS_OK;
          r.element    = shadow_ring[ring_pos(pos)];
          r.final_item = (pos == int'(shadow_len) - 1);
          pending_results.push_back(r);
        end
      end
      REQ_CLEAR: begin
        shadow_len  = '0;
        shadow_head = '0;
      end
      default: begin
      end
    endcase
  endtask

  // sends one request word; valid stays high into the next call when no gap
  task automatic send_word(input logic [2:0] req, input logic signed [DATA_W-1:0] val);
    dls_in_t w;
    int      gap;
    w.req_type   = req;
    w.push_value = val;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (in_stall_o);
    model_request(w);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic check_result(input dls_out_t got);
    dls_out_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result word %h", got));
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.element !== want.element)
        report_mismatch($sformatf("element %0d, want %0d", got.element, want.element));
      if (got.final_item !== want.final_item)
        report_mismatch($sformatf("final_item %b, want %b", got.final_item,
                                  want.final_item));
    end
  endtask

  // sample at the rising edge, compare at the falling edge after it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen_word = out_o;
      @(negedge clk_i);
      check_result(seen_word);
    end
  end

  initial begin : result_stall
    int hold;
    int n;
    out_stall_i = 1'b0;
    forever begin
      hold = $urandom_range(1, 4);
      repeat (hold) @(negedge clk_i) out_stall_i <= 1'b0;
      n = idle_len();
      repeat (n) @(negedge clk_i) out_stall_i <= 1'b1;
    end
  end

  task automatic test_directed();
    // empty list: both drops fail, dump and spare codes give nothing
    send_word(REQ_DROP_FRONT, 32'sd11);
    send_word(REQ_DROP_BACK, -32'sd11);
    send_word(REQ_DUMP, '0);
    send_word(REQ_SPARE_A, 32'sh7FFF_FFFF);
    send_word(REQ_SPARE_B, 32'sh8000_0000);
    // push front from slot zero wraps the head
    send_word(REQ_PUSH_BACK, 32'sh7FFF_FFFF);
    send_word(REQ_PUSH_FRONT, 32'sh8000_0000);
    send_word(REQ_PUSH_BACK, '0);
    send_word(REQ_PUSH_FRONT, -32'sd1);
    send_word(REQ_DUMP, -32'sd1);
    send_word(REQ_DROP_FRONT, '0);
    send_word(REQ_DROP_BACK, '0);
    send_word(REQ_DUMP, '0);
    send_word(REQ_CLEAR, 32'sh5555_5555);
    send_word(REQ_DUMP, '0);
    send_word(REQ_DROP_BACK, '0);
    send_word(REQ_PUSH_FRONT, 32'sh2AAA_AAAA);
    send_word(REQ_DUMP, '0);
    send_word(REQ_DROP_BACK, '0);
    send_word(REQ_DROP_FRONT, '0);
  endtask

  task automatic test_drain_pause();
    send_word(REQ_PUSH_BACK, $urandom);
    send_word(REQ_PUSH_FRONT, $urandom);
    send_word(REQ_PUSH_BACK, $urandom);
    send_word(REQ_DUMP, '0);
    hold_until_drained();
    send_word(REQ_DROP_FRONT, '0);
    send_word(REQ_DUMP, '0);
    hold_until_drained();
  endtask

  // fill to capacity from both ends, overflow, dump, then empty it again
  task automatic test_fill_and_empty();
    while (int'(shadow_len) < RING_SLOTS)
      send_word($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, any_value());
    send_word(REQ_PUSH_FRONT, any_value());
    send_word(REQ_PUSH_BACK, any_value());
    send_word(REQ_DUMP, any_value());
    while (shadow_len != '0)
      send_word($urandom_range(0, 1) ? REQ_DROP_BACK : REQ_DROP_FRONT, any_value());
    send_word($urandom_range(0, 1) ? REQ_DROP_BACK : REQ_DROP_FRONT, any_value());
  endtask

  task automatic test_random_mix(input int count);
    int k;
    int r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (k == count / 2) calm = 1'b1;
      if (k == count / 2 + 40) calm = 1'b0;
      if (r < 22)      send_word(REQ_PUSH_FRONT, any_value());
      else if (r < 44) send_word(REQ_PUSH_BACK, any_value());
      else if (r < 60) send_word(REQ_DROP_FRONT, any_value());
      else if (r < 76) send_word(REQ_DROP_BACK, any_value());
      else if (r < 86) send_word(REQ_DUMP, any_value());
      else if (r < 91) send_word(REQ_CLEAR, any_value());
      else if (r < 95) send_word($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B, $urandom);
      else             send_word(3'($urandom_range(0, 7)), $urandom);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_i       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_directed();
    test_drain_pause();
    calm = 1'b1;
    test_fill_and_empty();
    calm = 1'b0;
    test_fill_and_empty();
    test_random_mix(240);

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS double_ended_list_store_top");
    end else begin
      $display("FAIL double_ended_list_store_top");
    end
    $finish;
  end

endmodule

[files.f]
sv/dls_pkg.sv
sv/dls_ram.sv
sv/double_ended_list_store_top.sv
sv/dls_chk.sv
bench/tb_top.sv
